[design/bpmc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpmc_pkg
// Types, codes and helpers shared by the barcode prefix match counter.
// ----------------------------------------------------------------------------
package bpmc_pkg;

	// Action codes of an input beat.
	localparam logic [1:0] ACT_LOAD     = 2'd0;
	localparam logic [1:0] ACT_CLASSIFY = 2'd1;
	localparam logic [1:0] ACT_READ     = 2'd2;
	localparam logic [1:0] ACT_CLEAR    = 2'd3;

	// Status codes of a result beat.
	localparam logic [1:0] STS_OK       = 2'd0;
	localparam logic [1:0] STS_NO_MATCH = 2'd1;
	localparam logic [1:0] STS_SHORT    = 2'd2;
	localparam logic [1:0] STS_FULL     = 2'd3;

	// Shortest barcode that may be loaded, and the reset of min_length.
	localparam logic [5:0] MIN_LOAD_LEN     = 6'd15;
	localparam logic [5:0] MIN_LENGTH_RESET = 6'd17;

	typedef struct packed {
		logic [1:0]  action;
		logic [63:0] bases;
		logic [5:0]  base_count;
		logic [31:0] other_mask;
		logic [9:0]  entry_index;
	} in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [9:0]  hit_index;
		logic [5:0]  match_length;
		logic [31:0] counter_value;
	} out_t;

	// A sequence cut to a length, with base bits cleared at masked positions.
	typedef struct packed {
		logic [63:0] bases;
		logic [31:0] other_mask;
	} norm_t;

	// One row of the barcode table.
	typedef struct packed {
		logic [63:0] bases;
		logic [31:0] other_mask;
		logic [5:0]  length;
	} entry_t;

	// The read being classified and the window of lengths that are tried.
	typedef struct packed {
		logic [63:0] bases;
		logic [31:0] other_mask;
		logic [5:0]  top_len;
		logic [6:0]  low_sum;
		logic [5:0]  longest;
	} query_t;

	// Keep len bases and clear the base bits of non-ACGT positions.
	function automatic norm_t normalize(input logic [63:0] bases,
			input logic [31:0] omask, input logic [5:0] len);
		norm_t r;
		logic  keep;
		for (int i = 0; i < 32; i++) begin
			keep = (6'(i) < len);
			r.other_mask[i] = omask[i] & keep;
			r.bases[2*i +: 2] = (keep && !omask[i]) ? bases[2*i +: 2] : 2'b00;
		end
		return r;
	endfunction

endpackage

[design/barcode_prefix_match_counter.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// barcode_prefix_match_counter
// Barcode table with exact longest-prefix matching and saturating hit counts.
// ----------------------------------------------------------------------------
// Usage:
//   An input beat (in_valid high, in_stall low) carries one action: load a
//   barcode, classify a read, read a counter, or clear the table. Each beat
//   yields exactly one result beat on the output channel (out_valid/out_stall).
//   min_length is written through cfg_we/cfg_wdata; write it only while the
//   block is idle, as the block itself does not enforce this. Load, clear
//   and bad-index reads go straight to the result state; a counter read
//   first reads the row. A classify with rows to try has one compare unit walk
//   the entry memory one row per cycle and keep the longest matching row, lowest
//   index first; then the winner's counter is read and updated.
//   in_stall is high while an item is in work, so one item is in flight and
//   the next beat is taken in the cycle after the result is registered.
//   The output register holds one result; the next item is taken while it
//   waits, and its result waits inside the block while out_stall is high.
//   After reset the table is empty and min_length is 17; no clearing pass
//   is run, as rows at or above the entry count are never read.
// ----------------------------------------------------------------------------
module barcode_prefix_match_counter #(
	parameter int MAX_ENTRIES = 1024,
	parameter int MAX_BASES   = 32,
	parameter int COUNT_WIDTH = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire bpmc_pkg::in_t    in_data,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output bpmc_pkg::out_t        out_data,
	input  wire logic             cfg_we,
	input  wire logic [5:0]       cfg_wdata
);

	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int TW = $clog2(MAX_ENTRIES + 1);
	localparam int EW = $bits(bpmc_pkg::entry_t);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_SLAST = 3'd2;
	localparam logic [2:0] ST_SEVAL = 3'd3;
	localparam logic [2:0] ST_CUPD  = 3'd4;
	localparam logic [2:0] ST_RDC   = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0]             state_q;
	logic [5:0]             min_len_q;
	logic [TW-1:0]          total_q;
	logic [5:0]             longest_q;
	logic [TW-1:0]          scan_idx_q;
	logic                   valid_s1;
	logic [AW-1:0]          idx_s1;
	logic                   found_q;
	logic [AW-1:0]          best_idx_q;
	logic [5:0]             best_len_q;
	bpmc_pkg::query_t       query_q;
	bpmc_pkg::out_t         res_q;

	logic                   accept;
	logic [5:0]             n_sat;
	logic [5:0]             top_len;
	bpmc_pkg::norm_t        ld_norm;
	bpmc_pkg::out_t         acc_res;
	logic [TW+9:0]          eidx_ext;
	logic [TW+9:0]          total_ext;
	logic                   eidx_bad;
	logic [AW+9:0]          total_idx_ext;
	logic [AW+9:0]          eidx_idx_ext;
	logic [AW+9:0]          best_idx_ext;
	logic [AW-1:0]          rd_addr;
	logic                   ent_we;
	bpmc_pkg::entry_t       ent_wdata;
	bpmc_pkg::entry_t       ent_rdata;
	logic                   cnt_we;
	logic [AW-1:0]          cnt_waddr;
	logic [COUNT_WIDTH-1:0] cnt_wdata;
	logic [COUNT_WIDTH-1:0] cnt_rdata;
	logic [COUNT_WIDTH-1:0] cnt_inc;
	logic [COUNT_WIDTH+31:0] cnt_inc_ext;
	logic [COUNT_WIDTH+31:0] cnt_rd_ext;
	logic                   hit;
	logic                   out_free;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;

	// Length of the beat, capped at the largest barcode.
	assign n_sat   = (in_data.base_count > 6'(MAX_BASES)) ? 6'(MAX_BASES) :
		in_data.base_count;
	assign top_len = (n_sat < longest_q) ? n_sat : longest_q;
	assign ld_norm = bpmc_pkg::normalize(in_data.bases, in_data.other_mask, n_sat);

	// Index widening and range checks.
	assign eidx_ext      = {{TW{1'b0}}, in_data.entry_index};
	assign total_ext     = {10'b0, total_q};
	assign eidx_bad      = (eidx_ext >= total_ext);
	assign eidx_idx_ext  = {{AW{1'b0}}, in_data.entry_index};
	assign total_idx_ext = {10'b0, total_q[AW-1:0]};
	assign best_idx_ext  = {10'b0, best_idx_q};

	// Saturating increment of the winner's counter.
	assign cnt_inc     = (&cnt_rdata) ? cnt_rdata : (cnt_rdata + 1'b1);
	assign cnt_inc_ext = {32'b0, cnt_inc};
	assign cnt_rd_ext  = {32'b0, cnt_rdata};

	// Shared read address of both memories.
	always_comb begin
		case (state_q)
			ST_IDLE:  rd_addr = eidx_ext[AW-1:0];
			ST_SCAN:  rd_addr = scan_idx_q[AW-1:0];
			default:  rd_addr = best_idx_q;
		endcase
	end

	// Table writes: a load fills a row and zeroes its counter; a counter update writes the winner's counter.
	always_comb begin
		ent_we           = 1'b0;
		ent_wdata.bases      = ld_norm.bases;
		ent_wdata.other_mask = ld_norm.other_mask;
		ent_wdata.length     = n_sat;
		cnt_we           = 1'b0;
		cnt_waddr        = total_q[AW-1:0];
		cnt_wdata        = '0;
		if (accept && (in_data.action == bpmc_pkg::ACT_LOAD) &&
				(total_q != TW'(MAX_ENTRIES)) && (n_sat >= bpmc_pkg::MIN_LOAD_LEN)) begin
			ent_we = 1'b1;
			cnt_we = 1'b1;
		end else if (state_q == ST_CUPD) begin
			cnt_we    = 1'b1;
			cnt_waddr = best_idx_q;
			cnt_wdata = cnt_inc;
		end
	end

	bpmc_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_ENTRIES)
	) u_entry_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (total_q[AW-1:0]),
		.wdata (ent_wdata),
		.raddr (rd_addr),
		.rdata (ent_rdata)
	);

	bpmc_ram #(
		.WIDTH (COUNT_WIDTH),
		.DEPTH (MAX_ENTRIES)
	) u_count_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.raddr (rd_addr),
		.rdata (cnt_rdata)
	);

	bpmc_match u_match (
		.entry (ent_rdata),
		.query (query_q),
		.hit   (hit)
	);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q <= bpmc_pkg::MIN_LENGTH_RESET;
		end else if (cfg_we) begin
			min_len_q <= cfg_wdata;
		end
	end

	// Compare stage: the row read last cycle is checked against the read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (state_q == ST_SCAN);
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_idx_q[AW-1:0];
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			total_q    <= '0;
			longest_q  <= '0;
			scan_idx_q <= '0;
			found_q    <= 1'b0;
			best_idx_q <= '0;
			best_len_q <= '0;
			out_valid  <= 1'b0;
		end else begin
			if (out_valid && !out_stall && (state_q != ST_DONE)) begin
				out_valid <= 1'b0;
			end
			if (valid_s1 && hit && (!found_q || (ent_rdata.length > best_len_q))) begin
				found_q    <= 1'b1;
				best_idx_q <= idx_s1;
				best_len_q <= ent_rdata.length;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (in_data.action)
							bpmc_pkg::ACT_LOAD: begin
								state_q <= ST_DONE;
								if (total_q != TW'(MAX_ENTRIES)) begin
									if (n_sat > longest_q) begin
										longest_q <= n_sat;
									end
									if (n_sat >= bpmc_pkg::MIN_LOAD_LEN) begin
										total_q <= total_q + 1'b1;
									end
								end
							end
							bpmc_pkg::ACT_CLASSIFY: begin
								scan_idx_q <= '0;
								found_q    <= 1'b0;
								if ((min_len_q <= longest_q) && (total_q != '0)) begin
									state_q <= ST_SCAN;
								end else begin
									state_q <= ST_DONE;
								end
							end
							bpmc_pkg::ACT_READ: begin
								if (!eidx_bad) begin
									state_q <= ST_RDC;
								end else begin
									state_q <= ST_DONE;
								end
							end
							default: begin
								state_q   <= ST_DONE;
								total_q   <= '0;
								longest_q <= '0;
							end
						endcase
					end
				end
				ST_SCAN: begin
					scan_idx_q <= scan_idx_q + 1'b1;
					if (scan_idx_q == (total_q - 1'b1)) begin
						state_q <= ST_SLAST;
					end
				end
				ST_SLAST: begin
					state_q <= ST_SEVAL;
				end
				ST_SEVAL: begin
					state_q <= found_q ? ST_CUPD : ST_DONE;
				end
				ST_CUPD: begin
					state_q <= ST_DONE;
				end
				ST_RDC: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// First view of the result, decided when the beat is taken.
	always_comb begin
		acc_res = '0;
		case (in_data.action)
			bpmc_pkg::ACT_LOAD: begin
				acc_res.match_length = n_sat;
				if (total_q == TW'(MAX_ENTRIES)) begin
					acc_res.status = bpmc_pkg::STS_FULL;
				end else if (n_sat < bpmc_pkg::MIN_LOAD_LEN) begin
					acc_res.status = bpmc_pkg::STS_SHORT;
				end else begin
					acc_res.hit_index = total_idx_ext[9:0];
				end
			end
			bpmc_pkg::ACT_CLASSIFY: begin
				acc_res.status = bpmc_pkg::STS_NO_MATCH;
			end
			bpmc_pkg::ACT_READ: begin
				if (eidx_bad) begin
					acc_res.status = bpmc_pkg::STS_FULL;
				end else begin
					acc_res.hit_index = eidx_idx_ext[9:0];
				end
			end
			default: begin
				acc_res.status = bpmc_pkg::STS_OK;
			end
		endcase
	end

	// Result assembly and output register.
	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			out_data <= res_q;
		end
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					res_q <= acc_res;
					if (in_data.action == bpmc_pkg::ACT_CLASSIFY) begin
						query_q.bases      <= in_data.bases;
						query_q.other_mask <= in_data.other_mask;
						query_q.top_len    <= top_len;
						query_q.low_sum    <= 7'(top_len) + 7'(min_len_q);
						query_q.longest    <= longest_q;
					end
				end
			end
			ST_CUPD: begin
				res_q.status        <= bpmc_pkg::STS_OK;
				res_q.hit_index     <= best_idx_ext[9:0];
				res_q.match_length  <= best_len_q;
				res_q.counter_value <= cnt_inc_ext[31:0];
			end
			ST_RDC: begin
				res_q.match_length  <= ent_rdata.length;
				res_q.counter_value <= cnt_rd_ext[31:0];
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	// A result appears only after the sequencer has finished an item.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_DONE))
		else $error("result beat without a finished item");

	// The entry count never passes the table size.
	assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= TW'(MAX_ENTRIES))
		else $error("entry count beyond table size");

	// The scan only walks rows that were loaded.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (scan_idx_q < total_q))
		else $error("scan beyond loaded rows");

	// A counter update always has a winner no longer than the top tried length.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CUPD) |-> (found_q && (best_len_q <= query_q.top_len)))
		else $error("counter update without a valid winner");

endmodule
`default_nettype wire

[design/bpmc_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpmc_ram
// Generic memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module bpmc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[design/bpmc_match.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpmc_match
// Compare unit: checks one table row against the read at the row's length.
// ----------------------------------------------------------------------------
module bpmc_match (
	input  wire bpmc_pkg::entry_t entry,
	input  wire bpmc_pkg::query_t query,
	output logic                  hit
);

	bpmc_pkg::norm_t rd_norm;
	logic            in_window;

	// The read cut to the row's length, as it would be stored.
	assign rd_norm = bpmc_pkg::normalize(query.bases, query.other_mask, entry.length);

	// The row's length must be one of the lengths the search tries.
	assign in_window = (entry.length <= query.top_len) &&
		((7'(entry.length) + 7'(query.longest)) >= query.low_sum) &&
		(entry.length != 6'd0);

	assign hit = in_window && (rd_norm.bases == entry.bases) &&
		(rd_norm.other_mask == entry.other_mask);

endmodule
`default_nettype wire

[sim/tb_barcode_prefix_match_counter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_barcode_prefix_match_counter
// Self-checking bench for the barcode table. It loads barcodes, classifies
// reads, reads counters and clears the table under varied handshake pressure.
// Every result beat is checked field by field against a local table model.
// ----------------------------------------------------------------------------
module tb_barcode_prefix_match_counter;

	localparam int TABLE_DEPTH = 1024;
	localparam int CYCLE_LIMIT = 3000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	bpmc_pkg::in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	bpmc_pkg::out_t out_data;
	logic cfg_we = 1'b0;
	logic [5:0] cfg_wdata = '0;

	barcode_prefix_match_counter u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// Clock: 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Local copy of the barcode table.
	bit [63:0] tbl_bases [TABLE_DEPTH];
	bit [31:0] tbl_mask [TABLE_DEPTH];
	bit [5:0]  tbl_len [TABLE_DEPTH];
	bit [31:0] tbl_hits [TABLE_DEPTH];
	int        tbl_count = 0;
	int        longest_len = 0;
	int        min_len = bpmc_pkg::MIN_LENGTH_RESET;

	bpmc_pkg::out_t pending_results [$];
	int        error_count = 0;
	int        beats_sent = 0;
	int        beats_checked = 0;
	int        hits_seen = 0;
	int        idle_pct = 0;
	int        stall_pct = 0;
	int        hold_cycles = 0;
	int        cycle_count = 0;

	// Keep len bases and clear base bits at non-ACGT positions.
	function automatic void crop_seq(input bit [63:0] b, input bit [31:0] m,
			input int len, output bit [63:0] nb, output bit [31:0] nm);
		nb = '0;
		nm = '0;
		for (int i = 0; i < 32 && i < len; i++) begin
			nm[i] = m[i];
			if (!m[i])
				nb[2*i +: 2] = b[2*i +: 2];
		end
	endfunction

	// Work out the result of one accepted beat and update the table copy.
	function automatic bpmc_pkg::out_t predict_outcome(input bpmc_pkg::in_t item);
		bpmc_pkg::out_t r;
		int n;
		int top;
		int tries;
		int len;
		bit found;
		bit [63:0] rb;
		bit [31:0] rm;
		r = '0;
		n = (item.base_count > 32) ? 32 : int'(item.base_count);
		case (item.action)
			bpmc_pkg::ACT_LOAD: begin
				r.match_length = 6'(n);
				if (tbl_count >= TABLE_DEPTH) begin
					r.status = bpmc_pkg::STS_FULL;
				end else begin
					if (n > longest_len)
						longest_len = n;
					if (n < bpmc_pkg::MIN_LOAD_LEN) begin
						r.status = bpmc_pkg::STS_SHORT;
					end else begin
						crop_seq(item.bases, item.other_mask, n, rb, rm);
						tbl_bases[tbl_count] = rb;
						tbl_mask[tbl_count] = rm;
						tbl_len[tbl_count] = 6'(n);
						tbl_hits[tbl_count] = 0;
						r.hit_index = 10'(tbl_count);
						tbl_count++;
					end
				end
			end
			bpmc_pkg::ACT_CLASSIFY: begin
				top = (n < longest_len) ? n : longest_len;
				tries = longest_len - min_len + 1;
				found = 1'b0;
				for (int c = 0; c < tries && !found; c++) begin
					len = top - c;
					if (len <= 0)
						break;
					crop_seq(item.bases, item.other_mask, len, rb, rm);
					for (int i = 0; i < tbl_count; i++) begin
						if (tbl_len[i] == len && tbl_mask[i] == rm && tbl_bases[i] == rb) begin
							if (tbl_hits[i] != 32'hFFFF_FFFF)
								tbl_hits[i]++;
							r.hit_index = 10'(i);
							r.match_length = 6'(len);
							r.counter_value = tbl_hits[i];
							found = 1'b1;
							break;
						end
					end
				end
				if (!found)
					r.status = bpmc_pkg::STS_NO_MATCH;
			end
			bpmc_pkg::ACT_READ: begin
				if (item.entry_index >= tbl_count) begin
					r.status = bpmc_pkg::STS_FULL;
				end else begin
					r.hit_index = item.entry_index;
					r.match_length = tbl_len[item.entry_index];
					r.counter_value = tbl_hits[item.entry_index];
				end
			end
			default: begin
				tbl_count = 0;
				longest_len = 0;
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string field, input longint got, input longint want);
		$display("ERROR beat %0d: %s got %0h, expected %0h", beats_checked, field, got, want);
		error_count++;
	endtask

	// Result checker: compare each accepted result beat with the oldest prediction.
	always @(posedge clk) begin
		bpmc_pkg::out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result beat", 1, 0);
			end else begin
				want = pending_results.pop_front();
				if (out_data.status != want.status)
					report_mismatch("status", out_data.status, want.status);
				if (out_data.hit_index != want.hit_index)
					report_mismatch("hit_index", out_data.hit_index, want.hit_index);
				if (out_data.match_length != want.match_length)
					report_mismatch("match_length", out_data.match_length, want.match_length);
				if (out_data.counter_value != want.counter_value)
					report_mismatch("counter_value", out_data.counter_value,
						want.counter_value);
				if (want.status == bpmc_pkg::STS_OK && want.counter_value != 0)
					hits_seen++;
			end
			beats_checked++;
		end
	end

	// Receiver: random stall, or a long hold-off while hold_cycles runs down.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("barcode_prefix_match_counter: mismatch");
			$finish;
		end
	end

	// Offer one beat, wait for it to be taken, and record its prediction.
	task automatic send_beat(input bpmc_pkg::in_t item);
		@(negedge clk);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do
			@(posedge clk);
		while (in_stall);
		pending_results.push_back(predict_outcome(item));
		beats_sent++;
	endtask

	function automatic bpmc_pkg::in_t make_beat(input logic [1:0] act, input bit [63:0] b,
			input int cnt, input bit [31:0] m, input int idx);
		bpmc_pkg::in_t t;
		t.action = act;
		t.bases = b;
		t.base_count = 6'(cnt);
		t.other_mask = m;
		t.entry_index = 10'(idx);
		return t;
	endfunction

	function automatic bit [63:0] rand_bases();
		return {$urandom, $urandom};
	endfunction

	// Mostly clean barcodes, sometimes a few non-ACGT positions.
	function automatic bit [31:0] rand_mask();
		if ($urandom_range(3) == 0)
			return $urandom & $urandom & $urandom;
		return '0;
	endfunction

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	// Register write once every result has come back and the block is idle.
	task automatic write_min_length(input int value);
		drain();
		repeat (tbl_count + 12) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= 6'(value);
		@(negedge clk);
		cfg_we <= 1'b0;
		min_len = value;
	endtask

	// A read built from entry k: same prefix, random tail, sometimes a broken base.
	function automatic bpmc_pkg::in_t read_from_entry(input int k);
		bit [63:0] b;
		bit [31:0] m;
		int len;
		int pos;
		len = tbl_len[k];
		b = rand_bases();
		m = rand_mask();
		for (int i = 0; i < 32; i++) begin
			if (i < len) begin
				m[i] = tbl_mask[k][i];
				if (!m[i])
					b[2*i +: 2] = tbl_bases[k][2*i +: 2];
			end
		end
		if ($urandom_range(4) == 0) begin
			pos = $urandom_range(len - 1);
			b[2*pos +: 2] = ~b[2*pos +: 2];
			m[pos] = 1'b0;
		end
		return make_beat(bpmc_pkg::ACT_CLASSIFY, b, $urandom_range(len, 32), m, $urandom);
	endfunction

	// Directed cases: field extremes, each action and each special case.
	task automatic test_directed();
		bpmc_pkg::in_t t;
		send_beat(make_beat(bpmc_pkg::ACT_CLASSIFY, '1, 32, '0, 0));  // empty table
		send_beat(make_beat(bpmc_pkg::ACT_READ, 0, 0, 0, 0));         // bad index
		send_beat(make_beat(bpmc_pkg::ACT_LOAD, '1, 14, '1, '1));     // too short
		send_beat(make_beat(bpmc_pkg::ACT_LOAD, '0, 0, '0, 0));       // zero length
		send_beat(make_beat(bpmc_pkg::ACT_LOAD, 64'h0123_4567_89AB_CDEF, 15, 0, 0));
		send_beat(make_beat(bpmc_pkg::ACT_LOAD, '1, 63, '0, 0));      // saturates to 32
		send_beat(make_beat(bpmc_pkg::ACT_LOAD, 64'hFFFF_0000_FFFF_0000, 20,
			32'h0000_0005, 0));
		// Duplicate of an earlier barcode.
		send_beat(make_beat(bpmc_pkg::ACT_LOAD, 64'h0123_4567_89AB_CDEF, 15, 0, 0));
		send_beat(make_beat(bpmc_pkg::ACT_CLASSIFY, '1, 63, '0, 0));  // full-length hit
		// Masked positions equal whatever their base bits hold.
		send_beat(make_beat(bpmc_pkg::ACT_CLASSIFY, 64'hFFFF_0000_FFFF_000F, 25,
			32'h0000_0005, 0));
		send_beat(make_beat(bpmc_pkg::ACT_CLASSIFY, 64'h0123_4567_89AB_CDEF, 17, 0, 0));
		send_beat(make_beat(bpmc_pkg::ACT_CLASSIFY, 64'hFFFF_FFFF_89AB_CDEF, 32, 0, 0));
		for (int i = 0; i < 5; i++)
			send_beat(make_beat(bpmc_pkg::ACT_READ, 0, 0, 0, i));
		send_beat(make_beat(bpmc_pkg::ACT_READ, 0, 0, 0, 10'h3FF));
		send_beat(make_beat(bpmc_pkg::ACT_CLEAR, '1, 63, '1, '1));
		send_beat(make_beat(bpmc_pkg::ACT_READ, 0, 0, 0, 0));
		send_beat(make_beat(bpmc_pkg::ACT_CLASSIFY, 64'h0123_4567_89AB_CDEF, 15, 0, 0));
		send_beat(make_beat(bpmc_pkg::ACT_LOAD, 64'h0123_4567_89AB_CDEF, 16, 0, 0));
		t = make_beat(bpmc_pkg::ACT_CLASSIFY, 64'h0123_4567_89AB_CDEF, 16, 0, 0);
		send_beat(t);
	endtask

	// Shortest tried length at its extremes: every crop, then only the top one.
	task automatic test_min_length_extremes();
		write_min_length(1);
		send_beat(make_beat(bpmc_pkg::ACT_CLEAR, 0, 0, 0, 0));
		send_beat(make_beat(bpmc_pkg::ACT_LOAD, 64'h0000_0000_0000_AAAA, 15, 0, 0));
		send_beat(make_beat(bpmc_pkg::ACT_LOAD, 64'h0000_0000_0000_5555, 32, 0, 0));
		send_beat(make_beat(bpmc_pkg::ACT_CLASSIFY, 64'hFFFF_FFFF_0000_AAAA, 32, 0, 0));
		send_beat(make_beat(bpmc_pkg::ACT_CLASSIFY, 64'h0000_0000_0000_5555, 32, 0, 0));
		write_min_length(32);
		send_beat(make_beat(bpmc_pkg::ACT_CLASSIFY, 64'hFFFF_FFFF_0000_AAAA, 32, 0, 0));
		send_beat(make_beat(bpmc_pkg::ACT_CLASSIFY, 64'h0000_0000_0000_5555, 40, 0, 0));
		send_beat(make_beat(bpmc_pkg::ACT_CLEAR, 0, 0, 0, 0));
	endtask

	// Fill every row, then try one load too many and a few lookups.
	task automatic test_table_full();
		send_beat(make_beat(bpmc_pkg::ACT_CLEAR, 0, 0, 0, 0));
		for (int i = 0; i < TABLE_DEPTH; i++)
			send_beat(make_beat(bpmc_pkg::ACT_LOAD, rand_bases(), $urandom_range(15, 32),
				rand_mask(), 0));
		send_beat(make_beat(bpmc_pkg::ACT_LOAD, rand_bases(), 32, 0, 0));
		send_beat(make_beat(bpmc_pkg::ACT_LOAD, rand_bases(), 3, 0, 0));
		send_beat(read_from_entry(TABLE_DEPTH - 1));
		send_beat(read_from_entry(500));
		send_beat(make_beat(bpmc_pkg::ACT_READ, 0, 0, 0, TABLE_DEPTH - 1));
		send_beat(make_beat(bpmc_pkg::ACT_CLEAR, 0, 0, 0, 0));
	endtask

	// Receiver holds off while the sender keeps offering, then the sender waits.
	task automatic test_back_pressure();
		hold_cycles = 400;
		for (int i = 0; i < 4; i++)
			send_beat(make_beat(bpmc_pkg::ACT_LOAD, rand_bases(),
				$urandom_range(15, 32), 0, 0));
		for (int i = 0; i < 4; i++)
			send_beat(make_beat(bpmc_pkg::ACT_READ, 0, 0, 0, $urandom_range(5)));
		drain();
		send_beat(make_beat(bpmc_pkg::ACT_READ, 0, 0, 0, 0));
	endtask

	// Random traffic: small tables of barcodes followed mostly by matching reads.
	task automatic test_random(input int count);
		int pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (tbl_count > 40 && pick < 8)
				send_beat(make_beat(bpmc_pkg::ACT_CLEAR, rand_bases(), $urandom_range(63),
					$urandom, $urandom));
			else if (tbl_count < 2 || pick < 30)
				send_beat(make_beat(bpmc_pkg::ACT_LOAD, rand_bases(),
					($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(15, 32),
					rand_mask(), $urandom));
			else if (pick < 75)
				send_beat(read_from_entry($urandom_range(tbl_count - 1)));
			else if (pick < 88)
				send_beat(make_beat(bpmc_pkg::ACT_READ, rand_bases(), $urandom_range(63),
					$urandom,
					($urandom_range(7) == 0) ? $urandom : $urandom_range(tbl_count - 1)));
			else
				send_beat(make_beat(bpmc_pkg::ACT_CLASSIFY, rand_bases(), $urandom_range(63),
					$urandom, $urandom));
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_min_length_extremes();
		write_min_length(15);
		test_table_full();
		test_back_pressure();

		// Handshake phases with a different shortest length in each.
		idle_pct = 0;  stall_pct = 0;
		test_random(180);
		write_min_length(20);
		idle_pct = 65; stall_pct = 0;
		test_random(180);
		write_min_length(1);
		idle_pct = 0;  stall_pct = 65;
		test_random(180);
		write_min_length(17);
		idle_pct = 6;  stall_pct = 6;
		test_random(180);

		drain();
		repeat (40) @(posedge clk);
		$display("Covered %0d beats, %0d results checked, %0d counter hits,",
			beats_sent, beats_checked, hits_seen);
		$display("with a full table, long hold-offs and four handshake phases.");
		if (error_count == 0 && pending_results.size() == 0)
			$display("barcode_prefix_match_counter: match");
		else
			$display("barcode_prefix_match_counter: mismatch");
		$finish;
	end

endmodule
